@@ src/progress_stall_watchdog_core_macros.svh @@
// Assertion macros shared by the progress stall watchdog RTL.
`ifndef PROGRESS_STALL_WATCHDOG_CORE_MACROS_SVH
`define PROGRESS_STALL_WATCHDOG_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/psw_pkg.sv @@
// Types and constants of the progress stall watchdog.
package psw_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] RESET_STALL_BEGIN_MS  = 32'd250;
  localparam logic [TimeW-1:0] RESET_STALL_REPEAT_MS = 32'd500;
  localparam logic [TimeW-1:0] RESET_WATCHDOG_MS     = 32'd5000;

  localparam logic [CfgIdxW-1:0] CFG_STALL_BEGIN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STALL_REPEAT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WATCHDOG     = 2'd2;

  typedef enum logic [1:0] {
    EV_STALL_BEGIN   = 2'd0,
    EV_STALL_ONGOING = 2'd1,
    EV_WATCHDOG      = 2'd2,
    EV_STALL_END     = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [TimeW-1:0] sim_tick;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] progress_mark;
  } in_item_t;

  typedef struct packed {
    event_kind_t      event_kind;
    logic [TimeW-1:0] event_tick;
    logic [TimeW-1:0] event_ms;
    logic [TimeW-1:0] stalled_for_ms;
    logic [TimeW-1:0] held_mark;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] stall_begin_ms;
    logic [TimeW-1:0] stall_repeat_ms;
    logic [TimeW-1:0] watchdog_ms;
  } cfg_t;

endpackage

@@ src/psw_cfg_regs.sv @@
// Configuration register file of the progress stall watchdog.
module psw_cfg_regs import psw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_STALL_BEGIN:  cfg_nxt.stall_begin_ms  = cfg_wdata;
        CFG_STALL_REPEAT: cfg_nxt.stall_repeat_ms = cfg_wdata;
        CFG_WATCHDOG:     cfg_nxt.watchdog_ms     = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_begin_ms  <= RESET_STALL_BEGIN_MS;
      cfg_r.stall_repeat_ms <= RESET_STALL_REPEAT_MS;
      cfg_r.watchdog_ms     <= RESET_WATCHDOG_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/psw_tracker.sv @@
// Progress tracking state and the per-item stall decision.
`include "progress_stall_watchdog_core_macros.svh"
module psw_tracker import psw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      step,
  input  in_item_t  item,
  output logic      emit,
  output out_item_t result
);

  logic             seen_any_r, seen_any_nxt;
  logic [TimeW-1:0] last_mark_r, last_mark_nxt;
  logic [TimeW-1:0] confirmed_r, confirmed_nxt;
  logic [TimeW-1:0] note_r, note_nxt;
  logic             stall_active_r, stall_active_nxt;
  logic             wd_done_r, wd_done_nxt;

  logic             changed;
  logic [TimeW-1:0] stalled;
  logic [TimeW-1:0] since_note;
  event_kind_t      kind;

  assign changed    = !seen_any_r || (item.progress_mark != last_mark_r);
  assign stalled    = item.now_ms - confirmed_r;
  assign since_note = item.now_ms - note_r;

  always_comb begin
    seen_any_nxt     = seen_any_r;
    last_mark_nxt    = last_mark_r;
    confirmed_nxt    = confirmed_r;
    note_nxt         = note_r;
    stall_active_nxt = stall_active_r;
    wd_done_nxt      = wd_done_r;
    emit             = 1'b0;
    kind             = EV_STALL_END;
    if (changed) begin
      seen_any_nxt     = 1'b1;
      last_mark_nxt    = item.progress_mark;
      confirmed_nxt    = item.now_ms;
      stall_active_nxt = 1'b0;
      wd_done_nxt      = 1'b0;
      emit             = stall_active_r;
      kind             = EV_STALL_END;
    end else if (!stall_active_r) begin
      if (stalled >= cfg.stall_begin_ms) begin
        stall_active_nxt = 1'b1;
        note_nxt         = item.now_ms;
        emit             = 1'b1;
        kind             = EV_STALL_BEGIN;
      end
    end else if (!wd_done_r && (stalled >= cfg.watchdog_ms)) begin
      wd_done_nxt = 1'b1;
      emit        = 1'b1;
      kind        = EV_WATCHDOG;
    end else if (since_note >= cfg.stall_repeat_ms) begin
      note_nxt = item.now_ms;
      emit     = 1'b1;
      kind     = EV_STALL_ONGOING;
    end
  end

  // held mark is the stored mark, but the new mark on a stall end
  always_comb begin
    result.event_kind     = kind;
    result.event_tick     = item.sim_tick;
    result.event_ms       = item.now_ms;
    result.stalled_for_ms = stalled;
    result.held_mark      = item.progress_mark;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_any_r     <= 1'b0;
      last_mark_r    <= '0;
      confirmed_r    <= '0;
      note_r         <= '0;
      stall_active_r <= 1'b0;
      wd_done_r      <= 1'b0;
    end else if (step) begin
      seen_any_r     <= seen_any_nxt;
      last_mark_r    <= last_mark_nxt;
      confirmed_r    <= confirmed_nxt;
      note_r         <= note_nxt;
      stall_active_r <= stall_active_nxt;
      wd_done_r      <= wd_done_nxt;
    end
  end

  `PSW_ASSERT_NOW(a_wd_in_stall, clk, rst_n, wd_done_r, stall_active_r, "watchdog flag outside stall")
  `PSW_ASSERT_NOW(a_stall_after_seen, clk, rst_n, stall_active_r, seen_any_r, "stall before first item")
  `PSW_ASSERT_NOW(a_end_needs_stall, clk, rst_n, step && emit && (kind == EV_STALL_END), stall_active_r, "stall end without stall")
  `PSW_ASSERT_NEXT(a_begin_opens, clk, rst_n, step && emit && (kind == EV_STALL_BEGIN), stall_active_r && !wd_done_r, "stall begin did not open stall")

endmodule

@@ src/progress_stall_watchdog_core.sv @@
// Top level of the progress stall watchdog: input register, tracker, result register.
//
//   channel | ports                              | direction
//   in      | in_valid, in_ready, in_data        | progress reports in
//   out     | out_valid, out_ready, out_data     | stall events out
//   cfg     | cfg_we, cfg_index, cfg_wdata       | threshold writes
//
// One report per cycle unless an untaken event stalls; out_valid rises only for events.
// The tracker decides and updates its state in the cycle the report moves
// from the input register into the result register.
// A stalled result register holds the input register; in_ready then drops.
// Synchronous active-low reset clears all control state and reloads the default thresholds.
`include "progress_stall_watchdog_core_macros.svh"
module progress_stall_watchdog_core import psw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_v_r;
  out_item_t out_item_r;
  logic      out_v_r;
  logic      adv;
  logic      emit;
  out_item_t result;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  psw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  psw_tracker u_trk (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (adv),
    .item   (in_item_r),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= emit;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  `PSW_ASSERT_NEXT(a_in_hold, clk, rst_n, in_v_r && !adv, in_v_r && $stable(in_item_r), "input item dropped")
  `PSW_ASSERT_NEXT(a_out_follows, clk, rst_n, adv, out_v_r == $past(emit), "result valid mismatch")
  `PSW_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_v_r && !out_ready, !adv, "pending result overwritten")

endmodule
